>>> src/s2u_pkg.sv
// ----------------------------------------------------------------------------
// s2u_pkg: shared constants and helpers for the string-to-u32 parser
// Character codes, base codes and the digit decode used by the parse stage.
// ----------------------------------------------------------------------------
package s2u_pkg;

  localparam int unsigned BASE_W = 6;
  localparam int unsigned CHAR_W = 8;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] NO_DIGIT  = 6'd36;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;

  // digit value 0..35, NO_DIGIT when the character is not alphanumeric
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = CHAR_W'(NO_DIGIT);
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      d = c - CH_LA + 8'd10;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      d = c - CH_UA + 8'd10;
    end
    return d[BASE_W-1:0];
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

endpackage

>>> src/string_to_u32_parser.sv
// The last character (or NUL) passes the input register, then the result register.
// Throughput: one character per cycle; the parse stage does one multiply-add by the
//   base per character between the input and result registers; string ends can stall.
// Reset (rst_n low, synchronous): parse state cleared, base register = 0 (auto),
//   both pipeline valids cleared.
// ----------------------------------------------------------------------------
// string_to_u32_parser: streaming string to unsigned integer converter
// Skips whitespace, takes an optional sign, detects 0x / leading-0 prefixes,
// accumulates digits in the selected base and reports value, overflow and
// the number of characters consumed when the string ends.
// ----------------------------------------------------------------------------
module string_to_u32_parser #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // configuration: number_base write
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,   // [5:0] number_base, [7:6] unused
  // characters in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  input  logic        in_tlast,    // last character of the string
  // results out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [((VALUE_BITS+OFFSET_BITS+7)/8)*8-1:0] out_tdata,
                                   // value, then end_offset, zero padded
  output logic        out_tuser    // overflow
);
  import s2u_pkg::*;

  localparam int unsigned OUT_W  = ((VALUE_BITS + OFFSET_BITS + 7) / 8) * 8;
  localparam int unsigned PROD_W = VALUE_BITS + BASE_W + 1;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // base register
  logic [BASE_W-1:0] number_base_r;

  // input register stage
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_ch_r;
  logic              s1_last_r;

  // parse state
  phase_t                 phase_r, phase_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic                   minus_r, minus_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [OFFSET_BITS-1:0] count_r, count_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r;
  logic                   out_ovf_r;

  // parse-stage working signals
  logic                   first_char;
  logic                   take_dig;
  logic                   count_inc;
  logic [BASE_W-1:0]      base_use;
  logic [BASE_W-1:0]      digit;
  logic [PROD_W-1:0]      prod;
  logic                   emit;
  logic                   out_free;
  logic                   s1_adv;
  logic [VALUE_BITS-1:0]  value_res;
  logic                   ovf_res;
  logic [OFFSET_BITS-1:0] count_res;

  assign cfg_tready = 1'b1;

  // Stage advance: a character with no result always moves on; one that
  // ends the string needs the result register free (or draining this cycle).
  assign emit      = s1_last_r || (s1_ch_r == CH_NUL);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  assign digit = digit_of(s1_ch_r);

  // Multiply-add by the base; any bit above VALUE_BITS means the magnitude
  // no longer fits (same test as acc > (max - d) / base).
  assign prod = PROD_W'(acc_r) * PROD_W'(base_use) + PROD_W'(digit);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    minus_nxt  = minus_r;
    ovf_nxt    = ovf_r;
    base_nxt   = base_r;
    count_nxt  = count_r;
    first_char = 1'b0;
    take_dig   = 1'b0;
    count_inc  = 1'b0;
    base_use   = base_r;

    case (phase_r)
      PH_SPACE: begin
        if (is_space(s1_ch_r)) begin
          count_inc = 1'b1;
        end else if (s1_ch_r == CH_MINUS || s1_ch_r == CH_PLUS) begin
          minus_nxt = (s1_ch_r == CH_MINUS);
          count_inc = 1'b1;
          phase_nxt = PH_PREFIX;
        end else begin
          first_char = 1'b1;
        end
      end
      PH_PREFIX: begin
        first_char = 1'b1;
      end
      PH_ZERO: begin
        if (s1_ch_r == CH_LX || s1_ch_r == CH_UX) begin
          base_nxt  = BASE_HEX;
          count_inc = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          // auto base with a lone leading zero falls back to octal
          base_use = (base_r == BASE_AUTO) ? BASE_OCT : base_r;
          base_nxt = base_use;
          take_dig = 1'b1;
        end
      end
      PH_DIGITS: begin
        take_dig = 1'b1;
      end
      default: begin
      end
    endcase

    // First character after whitespace and sign latches the base.
    if (first_char) begin
      if ((number_base_r == BASE_AUTO || number_base_r == BASE_HEX) && s1_ch_r == CH_0) begin
        base_nxt  = number_base_r;
        count_inc = 1'b1;
        phase_nxt = PH_ZERO;
      end else begin
        base_use = (number_base_r == BASE_AUTO) ? BASE_DEC : number_base_r;
        base_nxt = base_use;
        take_dig = 1'b1;
      end
    end

    if (take_dig) begin
      if (digit >= NO_DIGIT || digit >= base_use || base_use == BASE_AUTO) begin
        phase_nxt = PH_DONE;
      end else begin
        if (prod[PROD_W-1:VALUE_BITS] != '0) begin
          ovf_nxt = 1'b1;
        end
        acc_nxt   = prod[VALUE_BITS-1:0];
        count_inc = 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end

    // saturating consumed count
    if (count_inc && count_r != '1) begin
      count_nxt = count_r + 1'b1;
    end

    // result from the updated state
    if (ovf_nxt) begin
      value_res = '1;
    end else if (minus_nxt) begin
      value_res = '0 - acc_nxt;
    end else begin
      value_res = acc_nxt;
    end
    ovf_res   = ovf_nxt;
    count_res = count_nxt;

    // end of string: state returns to its reset values
    if (emit) begin
      phase_nxt = PH_SPACE;
      acc_nxt   = '0;
      minus_nxt = 1'b0;
      ovf_nxt   = 1'b0;
      base_nxt  = BASE_AUTO;
      count_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_adv && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_AUTO;
      s1_valid_r    <= 1'b0;
      phase_r       <= PH_SPACE;
      acc_r         <= '0;
      minus_r       <= 1'b0;
      ovf_r         <= 1'b0;
      base_r        <= BASE_AUTO;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_tvalid) begin
        number_base_r <= cfg_tdata[BASE_W-1:0];
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        minus_r <= minus_nxt;
        ovf_r   <= ovf_nxt;
        base_r  <= base_nxt;
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv && emit) begin
      out_data_r <= OUT_W'({count_res, value_res});
      out_ovf_r  <= ovf_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

endmodule
